FILE: rtl/core/angle_aware_linear_interpolator_macros.svh
// Assertion helpers shared by the interpolator modules.
// Each use needs clk_i and rst_ni in scope.
`ifndef ANGLE_AWARE_LINEAR_INTERPOLATOR_MACROS_SVH
`define ANGLE_AWARE_LINEAR_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define AALI_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("interpolator check failed");

// Next-cycle implication.
`define AALI_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("interpolator check failed");

`endif

FILE: rtl/core/aali_pkg.sv
package aali_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int WIDE_W    = DATA_W + 1;

  // Pi in fixed point, rounded to nearest
  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI_FX     = (PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
  localparam logic [63:0] TWO_PI_FX = PI_FX << 1;

  // Angle wrap: bias to a nonnegative value, then reciprocal divide by 2pi
  localparam int          WRAP_U_W   = DATA_W + 2;
  localparam int          WRAP_SH    = WRAP_U_W;
  localparam logic [63:0] WRAP_OFS   = TWO_PI_FX * ((64'd1 << (DATA_W - 1)) / TWO_PI_FX + 64'd1);
  localparam logic [63:0] WRAP_RECIP = (64'd1 << WRAP_SH) / TWO_PI_FX;
  localparam int          RECIP_W    = $clog2(WRAP_RECIP + 64'd1);
  localparam int          TWO_PI_W   = $clog2(TWO_PI_FX + 64'd1);
  localparam int          WRAP_LAT   = 3;

  // Scaled quotient
  localparam int QUO_W  = 41;
  localparam int PROD_W = 2 * WIDE_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int REM_W  = WIDE_W + 1;
  localparam logic [QUO_W-1:0] QUO_CLAMP = QUO_W'(1) << (QUO_W - 1);

  // Queue between front and back
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;
  localparam int FRONT_LAT  = WRAP_LAT + 1;

  // Action codes
  localparam logic ACT_LINEAR  = 1'b0;
  localparam logic ACT_ANGULAR = 1'b1;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] value_start;
    logic signed [DATA_W-1:0] position_start;
    logic signed [DATA_W-1:0] value_end;
    logic signed [DATA_W-1:0] position_end;
    logic signed [DATA_W-1:0] query_position;
  } aali_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interpolated;
    logic                     degenerate;
    logic                     saturated;
  } aali_out_t;

  typedef struct packed {
    logic                     angular;
    logic                     degen;
    logic signed [DATA_W-1:0] base;
    logic signed [WIDE_W-1:0] diff;
    logic signed [WIDE_W-1:0] offset;
    logic signed [WIDE_W-1:0] span;
  } aali_job_t;

endpackage

FILE: rtl/core/aali_wrap.sv
module aali_wrap (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [aali_pkg::DATA_W-1:0] x_i,
  output logic signed [aali_pkg::DATA_W-1:0] y_o
);
  import aali_pkg::*;

  localparam int M1_W = WRAP_U_W + RECIP_W;
  localparam int M2_W = RECIP_W + TWO_PI_W;

  logic [WRAP_U_W-1:0] u_s0;
  logic [WRAP_U_W-1:0] u1_q, u2_q;
  logic [M1_W-1:0]     m1_d, m1_q;
  logic [RECIP_W-1:0]  quo_s1;
  logic [M2_W-1:0]     qt_full;
  logic [WRAP_U_W-1:0] qt2_q;
  logic [WRAP_U_W-1:0] r_raw, r_fix;
  logic [DATA_W-1:0]   y_q;

  // Bias into a nonnegative range and estimate the turn count
  assign u_s0 = {{(WRAP_U_W - DATA_W){x_i[DATA_W-1]}}, x_i}
              + WRAP_U_W'(PI_FX + WRAP_OFS);
  assign m1_d = {{RECIP_W{1'b0}}, u_s0} * {{WRAP_U_W{1'b0}}, RECIP_W'(WRAP_RECIP)};

  // Multiply the turn count back by 2pi
  assign quo_s1  = m1_q[M1_W-1:WRAP_SH];
  assign qt_full = {{TWO_PI_W{1'b0}}, quo_s1} * {{RECIP_W{1'b0}}, TWO_PI_W'(TWO_PI_FX)};

  // Remainder with one correction step, then recenter
  always_comb begin
    r_raw = u2_q - qt2_q;
    r_fix = r_raw;
    if (r_raw >= WRAP_U_W'(TWO_PI_FX)) begin
      r_fix = r_raw - WRAP_U_W'(TWO_PI_FX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q  <= u_s0;
      m1_q  <= m1_d;
      u2_q  <= u1_q;
      qt2_q <= WRAP_U_W'(qt_full);
      y_q   <= DATA_W'(r_fix - WRAP_U_W'(PI_FX));
    end
  end

  assign y_o = $signed(y_q);

endmodule

FILE: rtl/core/aali_front.sv
module aali_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  aali_pkg::aali_in_t              in_data_i,
  input  logic [aali_pkg::FIFO_CW-1:0]    q_count_i,
  output logic                            push_o,
  output aali_pkg::aali_job_t             job_o
);
  import aali_pkg::*;

  typedef struct packed {
    logic                     angular;
    logic signed [DATA_W-1:0] v0;
    logic signed [DATA_W-1:0] v1;
    logic signed [WIDE_W-1:0] span;
    logic signed [WIDE_W-1:0] offset;
  } side_t;

  logic [15:0]              thr_q;
  logic [FRONT_LAT-1:0]     vld_q;
  side_t                    side_d;
  side_t                    side_q [WRAP_LAT];
  side_t                    side_w;
  logic signed [DATA_W-1:0] w0, w1;
  logic [FIFO_CW:0]         inflight;
  logic                     accept;
  logic signed [DATA_W+1:0] w0x, w1x, d_ang;
  logic signed [WIDE_W-1:0] d_lin;
  logic [WIDE_W-1:0]        span_mag;
  aali_job_t                job_d, job_q;

  localparam logic signed [DATA_W+1:0] PI_S     = $signed((DATA_W + 2)'(PI_FX));
  localparam logic signed [DATA_W+1:0] TWO_PI_S = $signed((DATA_W + 2)'(TWO_PI_FX));

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Admit a transfer only while the queue has room for everything in flight
  assign inflight   = (FIFO_CW + 1)'($countones(vld_q));
  assign in_ready_o = ({1'b0, q_count_i} + inflight) < (FIFO_CW + 1)'(FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_LAT-2:0], accept};
    end
  end

  // Differences taken at entry
  always_comb begin
    side_d.angular = (in_data_i.action == ACT_ANGULAR);
    side_d.v0      = in_data_i.value_start;
    side_d.v1      = in_data_i.value_end;
    side_d.span    = {in_data_i.position_end[DATA_W-1], in_data_i.position_end}
                   - {in_data_i.position_start[DATA_W-1], in_data_i.position_start};
    side_d.offset  = {in_data_i.query_position[DATA_W-1], in_data_i.query_position}
                   - {in_data_i.position_start[DATA_W-1], in_data_i.position_start};
  end

  // Hold side data alongside the wrap units
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < WRAP_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  aali_wrap u_wrap_start (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .x_i   (in_data_i.value_start),
    .y_o   (w0)
  );

  aali_wrap u_wrap_end (
    .clk_i (clk_i),
    .en_i  (1'b1),
    .x_i   (in_data_i.value_end),
    .y_o   (w1)
  );

  assign side_w = side_q[WRAP_LAT-1];

  // Classify: base, difference (short way for angles), degenerate span
  always_comb begin
    w0x   = {{2{w0[DATA_W-1]}}, w0};
    w1x   = {{2{w1[DATA_W-1]}}, w1};
    d_ang = w1x - w0x;
    if (d_ang > PI_S) begin
      d_ang = d_ang - TWO_PI_S;
    end else if (d_ang < -PI_S) begin
      d_ang = d_ang + TWO_PI_S;
    end
    d_lin    = {side_w.v1[DATA_W-1], side_w.v1} - {side_w.v0[DATA_W-1], side_w.v0};
    span_mag = side_w.span[WIDE_W-1] ? WIDE_W'(-side_w.span) : WIDE_W'(side_w.span);

    job_d.angular = side_w.angular;
    job_d.degen   = span_mag <= {{(WIDE_W - 16){1'b0}}, thr_q};
    job_d.base    = side_w.angular ? w0 : side_w.v0;
    job_d.diff    = side_w.angular ? $signed(WIDE_W'(d_ang)) : d_lin;
    job_d.offset  = side_w.offset;
    job_d.span    = side_w.span;
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign push_o = vld_q[FRONT_LAT-1];
  assign job_o  = job_q;

endmodule

FILE: rtl/core/aali_queue.sv
`include "angle_aware_linear_interpolator_macros.svh"

module aali_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  aali_pkg::aali_job_t          job_i,
  output logic                         job_valid_o,
  input  logic                         job_ready_i,
  output aali_pkg::aali_job_t          job_o,
  output logic [aali_pkg::FIFO_CW-1:0] count_o
);
  import aali_pkg::*;

  aali_job_t          mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               pop;

  assign job_valid_o = (count_q != '0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rptr_q];
  assign count_o     = count_q;

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop) begin
        count_q <= count_q + FIFO_CW'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - FIFO_CW'(1);
      end
    end
  end

  `AALI_ASSERT_IMP(a_no_overflow, push_i, (count_q < FIFO_CW'(FIFO_DEPTH)) || pop)
  `AALI_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FIFO_CW'(FIFO_DEPTH))
  `AALI_ASSERT_NXT(a_push_lands, push_i && !pop, count_q != '0)

endmodule

FILE: rtl/core/aali_back.sv
`include "angle_aware_linear_interpolator_macros.svh"

module aali_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  aali_pkg::aali_job_t job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aali_pkg::aali_out_t out_data_o
);
  import aali_pkg::*;

  localparam int N_ST  = QUO_W + 8;
  localparam int SUM_W = QUO_W + 2;

  typedef struct packed {
    logic                     ang;
    logic                     degen;
    logic                     neg;
    logic signed [DATA_W-1:0] base;
    logic [WIDE_W-1:0]        mag_d;
    logic [WIDE_W-1:0]        mag_o;
    logic [WIDE_W-1:0]        span;
  } s0_t;

  typedef struct packed {
    logic                     ang;
    logic                     degen;
    logic                     neg;
    logic signed [DATA_W-1:0] base;
    logic [PROD_W-1:0]        prod;
    logic [WIDE_W-1:0]        span;
  } s1_t;

  typedef struct packed {
    logic                     ang;
    logic                     degen;
    logic                     neg;
    logic                     big;
    logic signed [DATA_W-1:0] base;
    logic [REM_W-1:0]         den;
    logic [REM_W-1:0]         rem;
    logic [QUO_W-1:0]         low;
    logic [QUO_W-1:0]         quo;
  } div_t;

  typedef struct packed {
    logic                     ang;
    logic                     degen;
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } fin_t;

  logic [N_ST-1:0]          vld_q;
  logic                     en;
  logic                     pop;
  s0_t                      s0_d, s0_q;
  s1_t                      s1_q;
  div_t                     div_q [QUO_W+1];
  div_t                     div0_d;
  logic [NUM_W-1:0]         num;
  div_t                     last;
  logic [QUO_W-1:0]         qc;
  logic [SUM_W-1:0]         qmag;
  logic signed [SUM_W-1:0]  sum;
  logic                     ovf;
  fin_t                     fin_d, fin_q;
  fin_t                     ws_q [WRAP_LAT];
  logic signed [DATA_W-1:0] wy;
  aali_out_t                out_q;

  // Whole pipeline advances unless the result register is held
  assign en          = !vld_q[N_ST-1] || out_ready_i;
  assign job_ready_o = en;
  assign pop         = job_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[N_ST-2:0], pop};
    end
  end

  // Magnitudes and result sign
  always_comb begin
    s0_d.ang   = job_i.angular;
    s0_d.degen = job_i.degen;
    s0_d.neg   = job_i.diff[WIDE_W-1] ^ job_i.offset[WIDE_W-1] ^ job_i.span[WIDE_W-1];
    s0_d.base  = job_i.base;
    s0_d.mag_d = job_i.diff[WIDE_W-1] ? WIDE_W'(-job_i.diff) : WIDE_W'(job_i.diff);
    s0_d.mag_o = job_i.offset[WIDE_W-1] ? WIDE_W'(-job_i.offset) : WIDE_W'(job_i.offset);
    s0_d.span  = job_i.span[WIDE_W-1] ? WIDE_W'(-job_i.span) : WIDE_W'(job_i.span);
  end

  // Rounded division setup: (2P + S) / (2S), early check for a huge quotient
  always_comb begin
    num         = {s1_q.prod, 1'b0} + {{(NUM_W - WIDE_W){1'b0}}, s1_q.span};
    div0_d.ang   = s1_q.ang;
    div0_d.degen = s1_q.degen;
    div0_d.neg   = s1_q.neg;
    div0_d.base  = s1_q.base;
    div0_d.den   = {s1_q.span, 1'b0};
    div0_d.rem   = REM_W'(num[NUM_W-1:QUO_W]);
    div0_d.big   = REM_W'(num[NUM_W-1:QUO_W]) >= {s1_q.span, 1'b0};
    div0_d.low   = num[QUO_W-1:0];
    div0_d.quo   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q          <= s0_d;
      s1_q.ang      <= s0_q.ang;
      s1_q.degen    <= s0_q.degen;
      s1_q.neg      <= s0_q.neg;
      s1_q.base     <= s0_q.base;
      s1_q.span     <= s0_q.span;
      s1_q.prod     <= {{WIDE_W{1'b0}}, s0_q.mag_d} * {{WIDE_W{1'b0}}, s0_q.mag_o};
      div_q[0]      <= div0_d;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [REM_W:0] trial;
    div_t           nxt;

    always_comb begin
      trial = {div_q[k-1].rem, div_q[k-1].low[QUO_W-1]};
      nxt   = div_q[k-1];
      nxt.low = {div_q[k-1].low[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q[k-1].den}) begin
        nxt.rem = REM_W'(trial - {1'b0, div_q[k-1].den});
        nxt.quo = {div_q[k-1].quo[QUO_W-2:0], 1'b1};
      end else begin
        nxt.rem = REM_W'(trial);
        nxt.quo = {div_q[k-1].quo[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[k] <= nxt;
      end
    end
  end

  // Clamp quotient, add base, saturate to 32 bits; degenerate spans give the base
  assign last = div_q[QUO_W];

  always_comb begin
    qc   = (last.big || (last.quo > QUO_CLAMP)) ? QUO_CLAMP : last.quo;
    qmag = {2'b00, qc};
    sum  = $signed({{(SUM_W - DATA_W){last.base[DATA_W-1]}}, last.base})
         + $signed(last.neg ? -qmag : qmag);
    ovf  = (sum[SUM_W-1:DATA_W-1] != '0) && (sum[SUM_W-1:DATA_W-1] != '1);
    fin_d.ang   = last.ang;
    fin_d.degen = last.degen;
    if (last.degen) begin
      fin_d.sat = 1'b0;
      fin_d.val = last.base;
    end else if (ovf) begin
      fin_d.sat = 1'b1;
      fin_d.val = sum[SUM_W-1] ? $signed({1'b1, {(DATA_W - 1){1'b0}}})
                               : $signed({1'b0, {(DATA_W - 1){1'b1}}});
    end else begin
      fin_d.sat = 1'b0;
      fin_d.val = $signed(sum[DATA_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q    <= fin_d;
      ws_q[0]  <= fin_q;
      for (int i = 1; i < WRAP_LAT; i++) begin
        ws_q[i] <= ws_q[i-1];
      end
    end
  end

  aali_wrap u_wrap_out (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (fin_q.val),
    .y_o   (wy)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.interpolated <= ws_q[WRAP_LAT-1].ang ? wy : ws_q[WRAP_LAT-1].val;
      out_q.degenerate   <= ws_q[WRAP_LAT-1].degen;
      out_q.saturated    <= ws_q[WRAP_LAT-1].sat;
    end
  end

  assign out_valid_o = vld_q[N_ST-1];
  assign out_data_o  = out_q;

  `AALI_ASSERT_IMP(a_degen_no_sat, out_valid_o && out_data_o.degenerate, !out_data_o.saturated)
  `AALI_ASSERT_NXT(a_pop_enters, pop, vld_q[0])
  `AALI_ASSERT_NXT(a_out_held, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

endmodule

FILE: rtl/core/angle_aware_linear_interpolator.sv
// Throughput: one item per cycle; the front admits items while the 8-entry queue
//   has room for its 4 in-flight stages, and the back is a 49-stage pipeline
//   with a 41-stage restoring divider that stalls only while the result is held.
// Reset (rst_ni low, asynchronous): threshold 0, queue empty, no items in flight.
module angle_aware_linear_interpolator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aali_pkg::aali_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aali_pkg::aali_out_t out_data_o
);
  import aali_pkg::*;

  logic               push;
  aali_job_t          job_push, job_head;
  logic               job_valid, job_ready;
  logic [FIFO_CW-1:0] q_count;

  aali_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_count_i   (q_count),
    .push_o      (push),
    .job_o       (job_push)
  );

  aali_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job_push),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job_head),
    .count_o     (q_count)
  );

  aali_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job_head),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
